[design/iqagc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqagc_pkg
// Beat types, register map and fixed-point constants of the feedforward agc.
// ----------------------------------------------------------------------------
package iqagc_pkg;

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               end_of_block;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] i_out;
    logic signed [15:0] q_out;
    logic               block_last;
  } out_beat_t;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_DECAY   = 3'd2;
  localparam logic [2:0] REG_MAXGAIN = 3'd3;
  localparam logic [2:0] REG_TARGET  = 3'd4;

  localparam logic [30:0] ATTACK_RST  = 31'd1070315520;
  localparam logic [30:0] RELEASE_RST = 31'd1073793348;
  localparam logic [30:0] DECAY_RST   = 31'd1073536108;
  localparam logic [39:0] MAXGAIN_RST = 40'd1073741824000;
  localparam logic [15:0] TARGET_RST  = 16'd16384;

  localparam logic [30:0] ENV_RST    = 31'd1073741824;
  localparam logic [39:0] GAIN_RST   = 40'd1073741824;
  localparam logic [39:0] GAIN_FLOOR = 40'd10737418;
  localparam logic [30:0] ENV_MAX    = 31'h7FFFFFFF;
  localparam logic [15:0] RING_RST   = 16'd328;
  localparam logic [56:0] OUT_ROUND  = 57'd536870912;

endpackage

[design/iq_feedforward_agc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_feedforward_agc
// Peak-envelope agc on I/Q samples with a look-ahead delay ring.
// ----------------------------------------------------------------------------
// Each accepted beat runs through the accept cycle and then 13 sequencer
// steps, the accept cycle and the steps all sharing one registered 31x31
// unsigned multiplier (envelope decay, two halves of the level test, two
// halves of the gain ramp, two halves each of the I and Q scaling). in_stall
// stays high from the accept until the result beat is loaded into the output
// register; a loaded result may wait there while the next beat is accepted.
// The delay ring is one DELAY_DEPTH x 32 memory; a fill counter makes entries
// not yet written read as 0.01, so no clearing pass runs after reset.
module iq_feedforward_agc
  import iqagc_pkg::*;
#(
  parameter int DELAY_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_ENV_UPD = 14'b00000000000010,
    ST_LVL_HI  = 14'b00000000000100,
    ST_LVL_LO  = 14'b00000000001000,
    ST_LVL_CMP = 14'b00000000010000,
    ST_GAIN_HI = 14'b00000000100000,
    ST_GAIN_LO = 14'b00000001000000,
    ST_GAIN_SUM = 14'b00000010000000,
    ST_GAIN_CLP = 14'b00000100000000,
    ST_I_LO    = 14'b00001000000000,
    ST_I_HI    = 14'b00010000000000,
    ST_I_SUM   = 14'b00100000000000,
    ST_Q_HI    = 14'b01000000000000,
    ST_Q_SUM   = 14'b10000000000000
  } state_t;

  // configuration registers
  logic [30:0] attack_r, release_r, decay_r;
  logic [39:0] maxgain_r;
  logic [15:0] target_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
      decay_r   <= DECAY_RST;
      maxgain_r <= MAXGAIN_RST;
      target_r  <= TARGET_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_r  <= pwdata[30:0];
        REG_RELEASE: release_r <= pwdata[30:0];
        REG_DECAY:   decay_r   <= pwdata[30:0];
        REG_MAXGAIN: maxgain_r <= pwdata[39:0];
        REG_TARGET:  target_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATTACK:  prdata = {33'b0, attack_r};
      REG_RELEASE: prdata = {33'b0, release_r};
      REG_DECAY:   prdata = {33'b0, decay_r};
      REG_MAXGAIN: prdata = {24'b0, maxgain_r};
      REG_TARGET:  prdata = {48'b0, target_r};
      default:     prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_t      state_r, state_nxt;
  logic [30:0] env_r, env_nxt;
  logic [39:0] gain_r, gain_nxt;
  logic [AW-1:0] rd_r, fill_r, wr_pos;
  logic        rd_ok_r;
  logic [30:0] lvl_r;
  logic        eob_r;
  logic        hit_r;
  logic [31:0] rd_data_r;
  logic [51:0] acc_r;
  logic [61:0] prod_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;
  logic [15:0] res_i_r;

  logic        in_acc, out_free;
  logic [30:0] mul_a, mul_b;
  logic [30:0] factor;
  logic [15:0] smp_i, smp_q, mag_i, mag_q, mag_in;
  logic [31:0] env_dec;
  logic [51:0] part_sum;
  logic [56:0] out_sum;
  logic [41:0] graw;
  logic [39:0] gmax;

  logic [31:0] ring_mem [DELAY_DEPTH];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_pos = (rd_r == '0) ? LAST_POS : rd_r - AW'(1);

  assign smp_i = rd_ok_r ? rd_data_r[31:16] : RING_RST;
  assign smp_q = rd_ok_r ? rd_data_r[15:0] : RING_RST;
  assign mag_i = smp_i[15] ? (~smp_i + 16'd1) : smp_i;
  assign mag_q = smp_q[15] ? (~smp_q + 16'd1) : smp_q;
  assign mag_in = in_data.i_sample[15] ? (~in_data.i_sample + 16'd1) : in_data.i_sample;

  assign factor  = hit_r ? attack_r : release_r;
  assign env_dec = prod_r[61:30];
  assign part_sum = acc_r + {21'b0, prod_r[50:20]};
  assign out_sum  = {1'b0, prod_r[35:0], 20'b0} + {21'b0, acc_r[35:0]} + OUT_ROUND;
  assign graw     = acc_r[41:0];
  assign gmax     = (graw > {2'b0, maxgain_r}) ? maxgain_r : graw[39:0];

  function automatic logic [15:0] sat_out(input logic [26:0] r, input logic neg);
    logic [15:0] v;
    if (neg) begin
      v = (r > 27'd32768) ? 16'h8000 : (~r[15:0] + 16'd1);
    end else begin
      v = (r > 27'd32767) ? 16'h7FFF : r[15:0];
    end
    return v;
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_IDLE: begin
        mul_a = env_r;
        mul_b = decay_r;
      end
      ST_LVL_HI: begin
        mul_a = env_r;
        mul_b = {11'b0, gain_r[39:20]};
      end
      ST_LVL_LO: begin
        mul_a = env_r;
        mul_b = {11'b0, gain_r[19:0]};
      end
      ST_GAIN_HI: begin
        mul_a = factor;
        mul_b = {11'b0, gain_r[39:20]};
      end
      ST_GAIN_LO: begin
        mul_a = factor;
        mul_b = {11'b0, gain_r[19:0]};
      end
      ST_I_LO: begin
        mul_a = {15'b0, mag_i};
        mul_b = {11'b0, gain_r[19:0]};
      end
      ST_I_HI: begin
        mul_a = {15'b0, mag_i};
        mul_b = {11'b0, gain_r[39:20]};
      end
      ST_I_SUM: begin
        mul_a = {15'b0, mag_q};
        mul_b = {11'b0, gain_r[19:0]};
      end
      // q high half held while the result beat waits for the output register
      ST_Q_HI, ST_Q_SUM: begin
        mul_a = {15'b0, mag_q};
        mul_b = {11'b0, gain_r[39:20]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    env_nxt   = env_r;
    gain_nxt  = gain_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_ENV_UPD;
      ST_ENV_UPD: begin
        if (lvl_r > env_r) begin
          env_nxt = lvl_r;
        end else begin
          env_nxt = env_dec[31] ? ENV_MAX : env_dec[30:0];
        end
        state_nxt = ST_LVL_HI;
      end
      ST_LVL_HI:   state_nxt = ST_LVL_LO;
      ST_LVL_LO:   state_nxt = ST_LVL_CMP;
      ST_LVL_CMP:  state_nxt = ST_GAIN_HI;
      ST_GAIN_HI:  state_nxt = ST_GAIN_LO;
      ST_GAIN_LO:  state_nxt = ST_GAIN_SUM;
      ST_GAIN_SUM: state_nxt = ST_GAIN_CLP;
      ST_GAIN_CLP: begin
        gain_nxt  = (gmax < GAIN_FLOOR) ? GAIN_FLOOR : gmax;
        state_nxt = ST_I_LO;
      end
      ST_I_LO:     state_nxt = ST_I_HI;
      ST_I_HI:     state_nxt = ST_I_SUM;
      ST_I_SUM:    state_nxt = ST_Q_HI;
      ST_Q_HI:     state_nxt = ST_Q_SUM;
      ST_Q_SUM:    if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_r       <= ENV_RST;
      gain_r      <= GAIN_RST;
      rd_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      gain_r  <= gain_nxt;
      if (in_acc) begin
        rd_r <= (rd_r == LAST_POS) ? '0 : rd_r + AW'(1);
        if (fill_r != LAST_POS) fill_r <= fill_r + AW'(1);
      end
      if (state_r == ST_Q_SUM && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay ring
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wr_pos] <= {in_data.i_sample, in_data.q_sample};
      rd_data_r        <= ring_mem[rd_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= {31'b0, mul_a} * {31'b0, mul_b};
    if (in_acc) begin
      lvl_r   <= {mag_in, 15'b0};
      eob_r   <= in_data.end_of_block;
      rd_ok_r <= (fill_r == LAST_POS);
    end
    case (state_r)
      ST_LVL_LO:   acc_r <= {1'b0, prod_r[50:0]};
      ST_LVL_CMP:  hit_r <= (part_sum >= {11'b0, target_r, 25'b0});
      ST_GAIN_LO:  acc_r <= {1'b0, prod_r[50:0]};
      ST_GAIN_SUM: acc_r <= {10'b0, part_sum[51:10]};
      ST_I_HI:     acc_r <= {16'b0, prod_r[35:0]};
      ST_I_SUM: begin
        res_i_r <= sat_out(out_sum[56:30], smp_i[15]);
      end
      ST_Q_HI:     acc_r <= {16'b0, prod_r[35:0]};
      ST_Q_SUM: begin
        if (out_free) begin
          out_data_r.i_out      <= res_i_r;
          out_data_r.q_out      <= sat_out(out_sum[56:30], smp_q[15]);
          out_data_r.block_last <= eob_r;
        end
      end
      default: ;
    endcase
  end

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block ready right after accepting a beat");

  a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r >= GAIN_FLOOR)
    else $error("gain below floor");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_Q_SUM))
    else $error("result beat loaded outside final step");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (fill_r == LAST_POS) |=> fill_r == LAST_POS)
    else $error("fill counter left full state");

endmodule

[verif/iq_feedforward_agc_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_feedforward_agc_test
// Self-checking bench for the feedforward I/Q agc. Sample bursts of varying
// loudness flow through the block while its own peak-envelope and gain model
// predicts every delayed, scaled output beat. The APB registers are set to
// several settings (reset values, extremes, random) between bursts and read
// back. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module iq_feedforward_agc_test;
  import iqagc_pkg::*;

  localparam int DEPTH      = 256;
  localparam int STALL_LIM  = 4000;
  localparam int RAND_ITEMS = 155;
  localparam int N_PHASES   = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  iq_feedforward_agc #(.DELAY_DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // agc model state and registers
  logic [30:0] atk_f, rel_f, dec_f;
  logic [39:0] gain_max;
  logic [15:0] target;
  logic signed [15:0] ring_i [DEPTH];
  logic signed [15:0] ring_q [DEPTH];
  logic [7:0] rd_pos;
  logic [30:0] env;
  logic [39:0] gain;

  in_beat_t sample_queue[$];
  out_beat_t scaled_queue[$];
  out_beat_t predicted;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_pushed = 0;
  int n_settings = 0;
  int n_floor = 0;
  int n_ceil = 0;
  int n_sat = 0;
  int quiet_cnt = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t ns", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [63:0] reg_mask(logic [2:0] idx);
    case (idx)
      REG_ATTACK, REG_RELEASE, REG_DECAY: return 64'h7FFF_FFFF;
      REG_MAXGAIN: return 64'hFF_FFFF_FFFF;
      REG_TARGET: return 64'hFFFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [63:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_ATTACK: return 64'(atk_f);
      REG_RELEASE: return 64'(rel_f);
      REG_DECAY: return 64'(dec_f);
      REG_MAXGAIN: return 64'(gain_max);
      REG_TARGET: return 64'(target);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [15:0] scale_sample(logic signed [15:0] s,
                                                      logic [39:0] g);
    int sv;
    logic [63:0] mag, r;
    sv = s;
    mag = (sv < 0) ? 64'(-sv) : 64'(sv);
    r = (mag * 64'(g) + 64'd536870912) >> 30;
    if (sv < 0) begin
      if (r > 64'd32768) begin
        n_sat++;
        return -16'sd32768;
      end
      return -16'(r);
    end
    if (r > 64'd32767) begin
      n_sat++;
      return 16'sd32767;
    end
    return 16'(r);
  endfunction

  task automatic agc_step(input in_beat_t b, output out_beat_t r);
    int sv;
    logic [7:0] wr;
    logic [30:0] lvl;
    logic [63:0] dp;
    logic [71:0] prod, ramp;
    logic [30:0] factor;
    sv = b.i_sample;
    wr = rd_pos - 8'd1;
    ring_i[wr] = b.i_sample;
    ring_q[wr] = b.q_sample;
    lvl = 31'((sv < 0) ? -sv : sv) << 15;
    if (lvl > env) begin
      env = lvl;
    end else begin
      dp = (64'(env) * 64'(dec_f)) >> 30;
      env = (dp > 64'(ENV_MAX)) ? ENV_MAX : dp[30:0];
    end
    prod = 72'(env) * 72'(gain);
    factor = (prod >= (72'(target) << 45)) ? atk_f : rel_f;
    ramp = (72'(gain) * 72'(factor)) >> 30;
    if (ramp > 72'(gain_max)) begin
      ramp = 72'(gain_max);
      n_ceil++;
    end
    if (ramp < 72'(GAIN_FLOOR)) begin
      ramp = 72'(GAIN_FLOOR);
      n_floor++;
    end
    gain = ramp[39:0];
    r.i_out = scale_sample(ring_i[rd_pos], gain);
    r.q_out = scale_sample(ring_q[rd_pos], gain);
    r.block_last = b.end_of_block;
    rd_pos = rd_pos + 8'd1;
  endtask

  function automatic bit take_break();
    return !(n_in >= 300 && n_in < 460) && ($urandom_range(0, 99) < 11);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        agc_step(in_data, predicted);
        scaled_queue.push_back(predicted);
        n_in++;
      end
      if (sample_queue.size() > 0 && !take_break()) begin
        in_data <= sample_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (scaled_queue.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(out_data), '0);
        end else begin
          want = scaled_queue.pop_front();
          if (out_data.i_out !== want.i_out)
            report_mismatch("i_out", 64'(out_data.i_out), 64'(want.i_out));
          if (out_data.q_out !== want.q_out)
            report_mismatch("q_out", 64'(out_data.q_out), 64'(want.q_out));
          if (out_data.block_last !== want.block_last)
            report_mismatch("block_last", 64'(out_data.block_last), 64'(want.block_last));
        end
      end
      out_stall <= take_break();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIM) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIM);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    logic [63:0] wd;
    wd = val | (64'hA5C3_96F0_5A3C_690F & ~reg_mask(idx));
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ATTACK: atk_f = wd[30:0];
      REG_RELEASE: rel_f = wd[30:0];
      REG_DECAY: dec_f = wd[30:0];
      REG_MAXGAIN: gain_max = wd[39:0];
      REG_TARGET: target = wd[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_check(logic [2:0] idx);
    logic [63:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_value(idx))
      report_mismatch($sformatf("register %0d readback", idx), got, reg_value(idx));
  endtask

  task automatic apply_setting(logic [63:0] a, logic [63:0] r, logic [63:0] d,
                               logic [63:0] m, logic [63:0] t);
    cfg_write(REG_ATTACK, a);
    cfg_write(REG_RELEASE, r);
    cfg_write(REG_DECAY, d);
    cfg_write(REG_MAXGAIN, m);
    cfg_write(REG_TARGET, t);
    for (int k = 0; k <= 4; k++) cfg_check(3'(k));
    n_settings++;
  endtask

  task automatic push_sample(int i, int q, bit last);
    in_beat_t b;
    b.i_sample = 16'(i);
    b.q_sample = 16'(q);
    b.end_of_block = last;
    sample_queue.push_back(b);
    n_pushed++;
  endtask

  // bursts of one loudness class, so envelope and gain get to settle and move
  task automatic push_bursts(int count);
    int left, len, amp, i, q;
    left = count;
    while (left > 0) begin
      len = $urandom_range(6, 40);
      if (len > left) len = left;
      case ($urandom_range(0, 5))
        0: amp = 0;
        1: amp = 40;
        2: amp = 600;
        3: amp = 6000;
        4: amp = 20000;
        default: amp = -1;
      endcase
      for (int k = 0; k < len; k++) begin
        if (amp < 0 || $urandom_range(0, 19) == 0) begin
          i = int'(16'($urandom));
          q = int'(16'($urandom));
          if ($urandom_range(0, 9) == 0) i = $urandom_range(0, 1) ? -32768 : 32767;
        end else begin
          i = int'($urandom_range(0, 2 * amp)) - amp;
          q = int'($urandom_range(0, 2 * amp)) - amp;
        end
        push_sample(i, q, (k == len - 1) || ($urandom_range(0, 19) == 0));
      end
      left -= len;
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (n_out < n_pushed) @(posedge clk);
  endtask

  initial begin
    atk_f = ATTACK_RST;
    rel_f = RELEASE_RST;
    dec_f = DECAY_RST;
    gain_max = MAXGAIN_RST;
    target = TARGET_RST;
    for (int k = 0; k < DEPTH; k++) begin
      ring_i[k] = RING_RST;
      ring_q[k] = RING_RST;
    end
    rd_pos = '0;
    env = ENV_RST;
    gain = GAIN_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k <= 4; k++) cfg_check(3'(k));
    n_settings++;

    // field extremes and sign patterns at the reset setting
    push_sample(0, 0, 1'b0);
    push_sample(32767, -32768, 1'b1);
    push_sample(-32768, 32767, 1'b0);
    push_sample(-1, 1, 1'b1);
    push_sample(1, -1, 1'b0);
    push_sample(16384, -16384, 1'b0);
    push_sample(-16384, 16384, 1'b1);
    push_sample(328, -328, 1'b0);
    push_sample(21845, -21846, 1'b0);
    push_sample(-21846, 21845, 1'b1);
    push_sample(-32768, -32768, 1'b1);
    push_sample(32767, 32767, 1'b0);
    push_sample(0, 0, 1'b0);
    push_sample(3, -3, 1'b0);
    push_sample(0, 0, 1'b1);
    push_sample(-32767, 12345, 1'b0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: ;
        // unity attack, fastest release, instant envelope drop, widest ceiling
        1: apply_setting(64'd1073741824, 64'd2147483647, 64'd0,
                         64'hFF_FFFF_FFFF, 64'd32768);
        // zero attack, unity release and decay, ceiling at the floor
        2: apply_setting(64'd0, 64'd1073741824, 64'd1073741824,
                         64'd10737418, 64'd0);
        // decay above one, ceiling below the floor
        3: apply_setting(64'd1000000000, 64'd1100000000, 64'd2147483647,
                         64'd0, 64'd1);
        4: apply_setting(64'($urandom_range(1000000000, 1073741824)),
                         64'($urandom_range(1073741824, 1200000000)),
                         64'($urandom_range(1060000000, 1073741824)),
                         {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)},
                         64'($urandom_range(0, 32768)));
        default: begin
          apply_setting(64'(ATTACK_RST), 64'(RELEASE_RST), 64'(DECAY_RST),
                        64'(MAXGAIN_RST), 64'(TARGET_RST));
          // unmapped register index is ignored
          cfg_write(3'd5, 64'h1234);
          for (int k = 0; k <= 4; k++) cfg_check(3'(k));
        end
      endcase
      push_bursts(RAND_ITEMS);
      drain();
    end

    repeat (40) @(posedge clk);
    if (scaled_queue.size() > 0)
      report_mismatch("results never delivered", 64'(scaled_queue.size()), '0);
    $display("covered %0d sample beats in, %0d out, %0d register settings",
             n_in, n_out, n_settings);
    $display("gain held at floor %0d times, at ceiling %0d times; %0d saturated outputs",
             n_floor, n_ceil, n_sat);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
